FILE: src/pnst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point near segment test: shared definitions
// Coordinate width defaults, margin register layout, projection path codes
// and the default shape of the pipelined divider.
// ----------------------------------------------------------------------------
package pnst_pkg;

  localparam int COORD_BITS = 16;

  localparam int MARGIN_W = 8;
  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 8'd5;

  // Widths of the divider for the default coordinate width.
  localparam int DIFF_W    = COORD_BITS + 1;
  localparam int DIV_DEN_W = 2 * DIFF_W;
  localparam int DIV_NUM_W = DIFF_W + DIV_DEN_W;
  localparam int DIV_Q_W   = DIFF_W;
  localparam int DIV_TAG_W = 2 * DIFF_W;

  typedef enum logic [1:0] {
    PATH_A   = 2'd0,
    PATH_B   = 2'd1,
    PATH_MID = 2'd2
  } path_t;

endpackage

FILE: src/pnst_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per register stage, most significant first. A new item
// may enter in every cycle; the whole line holds while en is low.
// ----------------------------------------------------------------------------
module pnst_div #(
  parameter int NUM_W = pnst_pkg::DIV_NUM_W,
  parameter int DEN_W = pnst_pkg::DIV_DEN_W,
  parameter int Q_W   = pnst_pkg::DIV_Q_W,
  parameter int TAG_W = pnst_pkg::DIV_TAG_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [Q_W-1:0]   quo,
  output logic [TAG_W-1:0] out_tag
);

  localparam int RW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [Q_W-1:0]   valid_r;
  logic [RW-1:0]    rem_r [Q_W];
  logic [DEN_W-1:0] den_r [Q_W];
  logic [Q_W-1:0]   q_r   [Q_W];
  logic [TAG_W-1:0] tag_r [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    localparam int BIT = Q_W - 1 - k;

    logic             v_in;
    logic [RW-1:0]    rem_in;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   q_in;
    logic [TAG_W-1:0] tag_in;
    logic [RW-1:0]    shd;
    logic             ge;
    logic [RW-1:0]    rem_nxt;
    logic [Q_W-1:0]   q_nxt;

    if (k == 0) begin : g_first
      assign v_in   = in_valid;
      assign rem_in = RW'(num);
      assign den_in = den;
      assign q_in   = '0;
      assign tag_in = in_tag;
    end else begin : g_next
      assign v_in   = valid_r[k-1];
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign q_in   = q_r[k-1];
      assign tag_in = tag_r[k-1];
    end

    always_comb begin
      shd      = RW'(den_in) << BIT;
      ge       = (rem_in >= shd);
      rem_nxt  = ge ? (rem_in - shd) : rem_in;
      q_nxt    = q_in;
      q_nxt[BIT] = ge;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (en) begin
        valid_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        den_r[k] <= den_in;
        q_r[k]   <= q_nxt;
        tag_r[k] <= tag_in;
      end
    end
  end

  assign out_valid = valid_r[Q_W-1];
  assign quo       = q_r[Q_W-1];
  assign out_tag   = tag_r[Q_W-1];

endmodule

FILE: src/point_near_segment_test_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point near segment test
// Tests whether a point lies strictly within a margin of a line segment.
//
// The input channel carries one item per test: the point and both segment
// end points. The result channel returns one hit flag per item, in order.
// The margin register is written through cfg_wen and cfg_wdata. It is to be
// written only while no item is in flight; the block itself does not enforce
// this. Reset sets it to 5. Four stages handle differences, products, sums
// and the path select with the scaling multiply, then one divider stage per
// quotient bit, then offset, square and compare stages. One item is accepted
// per cycle while the receiver does not stall.
// Reset clears all valid bits, so nothing is in flight afterwards. When the
// receiver stalls with a result waiting, the whole pipeline holds and
// in_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module point_near_segment_test_top #(
  parameter int COORD_BITS = pnst_pkg::COORD_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // point_x, point_y, end_a_x, end_a_y, end_b_x, end_b_y from the lowest bit up.
  input  logic [((6*COORD_BITS+7)/8)*8-1:0] in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // hit in bit 0, zeros above.
  output logic [7:0]                    out_tdata,
  input  logic                          cfg_wen,
  input  logic [pnst_pkg::MARGIN_W-1:0] cfg_wdata
);

  localparam int N   = COORD_BITS;
  localparam int DW  = N + 1;
  localparam int PW  = 2 * DW;
  localparam int SW  = PW + 1;
  localparam int LW  = PW;
  localparam int NW  = DW + PW;
  localparam int QW  = DW;
  localparam int TW  = 2 * DW;
  localparam int EW  = DW + 2;
  localparam int QDW = 2 * EW;
  localparam int XW  = QDW + 1;
  localparam int MW  = pnst_pkg::MARGIN_W;

  logic adv;
  logic [MW-1:0]   margin_r;
  logic [2*MW-1:0] msq_r;

  logic signed [DW-1:0] px, py, ax, ay, bx, by;

  logic v1_r, v2_r, v3_r, v4_r, v6_r, v7_r, out_valid_r;
  logic signed [DW-1:0] a1_r, b1_r, c1_r, d1_r;
  logic signed [DW-1:0] a2_r, b2_r, c2_r, d2_r;
  logic signed [PW-1:0] ac_r, bd_r, cc_r, dd_r;
  logic signed [DW-1:0] a3_r, b3_r, c3_r, d3_r;
  logic signed [SW-1:0] dot_r;
  logic [LW-1:0]        len_r;

  pnst_pkg::path_t path3, path4_r, path5;
  logic [DW-1:0]        magc3, magd3;
  logic [PW-1:0]        dotu3;
  logic [NW-1:0]        numx_r, numy_r;
  logic [LW-1:0]        len4_r;
  logic signed [DW-1:0] a4_r, b4_r, c4_r, d4_r;

  logic                 vx5, vy5;
  logic [QW-1:0]        qx5, qy5;
  logic [TW+1:0]        tagx5;
  logic [TW-1:0]        tagy5;
  logic signed [DW-1:0] a5, b5, c5, d5;
  logic [DW-1:0]        magc5;
  logic signed [DW:0]   sx5, sy5;
  logic signed [EW-1:0] dx_nxt, dy_nxt, dx_r, dy_r;
  logic [QDW-1:0]       sqx_r, sqy_r;
  logic [XW-1:0]        dist7;
  logic                 hit_r;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  assign px = {in_tdata[N-1],   in_tdata[N-1:0]};
  assign py = {in_tdata[2*N-1], in_tdata[2*N-1:N]};
  assign ax = {in_tdata[3*N-1], in_tdata[3*N-1:2*N]};
  assign ay = {in_tdata[4*N-1], in_tdata[4*N-1:3*N]};
  assign bx = {in_tdata[5*N-1], in_tdata[5*N-1:4*N]};
  assign by = {in_tdata[6*N-1], in_tdata[6*N-1:5*N]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= pnst_pkg::MARGIN_RESET;
    end else if (cfg_wen) begin
      margin_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    msq_r <= margin_r * margin_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_tvalid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v6_r        <= vx5 && vy5;
      v7_r        <= v6_r;
      out_valid_r <= v7_r;
    end
  end

  always_comb begin
    if (dot_r[SW-1] || (dot_r == '0)) begin
      path3 = pnst_pkg::PATH_A;
    end else if (dot_r >= $signed({1'b0, len_r})) begin
      path3 = pnst_pkg::PATH_B;
    end else begin
      path3 = pnst_pkg::PATH_MID;
    end
    magc3 = c3_r[DW-1] ? DW'(-c3_r) : DW'(c3_r);
    magd3 = d3_r[DW-1] ? DW'(-d3_r) : DW'(d3_r);
    dotu3 = dot_r[PW-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1_r   <= px - ax;
      b1_r   <= py - ay;
      c1_r   <= bx - ax;
      d1_r   <= by - ay;
      ac_r   <= a1_r * c1_r;
      bd_r   <= b1_r * d1_r;
      cc_r   <= c1_r * c1_r;
      dd_r   <= d1_r * d1_r;
      a2_r   <= a1_r;
      b2_r   <= b1_r;
      c2_r   <= c1_r;
      d2_r   <= d1_r;
      dot_r  <= SW'(ac_r) + SW'(bd_r);
      len_r  <= LW'(cc_r) + LW'(dd_r);
      a3_r   <= a2_r;
      b3_r   <= b2_r;
      c3_r   <= c2_r;
      d3_r   <= d2_r;
      path4_r <= path3;
      numx_r <= NW'(magc3) * NW'(dotu3);
      numy_r <= NW'(magd3) * NW'(dotu3);
      len4_r <= len_r;
      a4_r   <= a3_r;
      b4_r   <= b3_r;
      c4_r   <= c3_r;
      d4_r   <= d3_r;
    end
  end

  pnst_div #(
    .NUM_W(NW),
    .DEN_W(LW),
    .Q_W  (QW),
    .TAG_W(TW + 2)
  ) u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (v4_r),
    .num      (numx_r),
    .den      (len4_r),
    .in_tag   ({path4_r, a4_r, c4_r}),
    .out_valid(vx5),
    .quo      (qx5),
    .out_tag  (tagx5)
  );

  pnst_div #(
    .NUM_W(NW),
    .DEN_W(LW),
    .Q_W  (QW),
    .TAG_W(TW)
  ) u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (v4_r),
    .num      (numy_r),
    .den      (len4_r),
    .in_tag   ({b4_r, d4_r}),
    .out_valid(vy5),
    .quo      (qy5),
    .out_tag  (tagy5)
  );

  always_comb begin
    path5 = pnst_pkg::path_t'(tagx5[TW+1:TW]);
    a5    = tagx5[TW-1:DW];
    c5    = tagx5[DW-1:0];
    b5    = tagy5[TW-1:DW];
    d5    = tagy5[DW-1:0];
    magc5 = c5[DW-1] ? DW'(-c5) : DW'(c5);
    sx5   = c5[DW-1] ? -$signed({1'b0, qx5}) : $signed({1'b0, qx5});
    sy5   = d5[DW-1] ? -$signed({1'b0, qy5}) : $signed({1'b0, qy5});
    case (path5)
      pnst_pkg::PATH_B: begin
        dx_nxt = EW'(a5) - EW'(c5);
        dy_nxt = EW'(b5) - EW'(d5);
      end
      pnst_pkg::PATH_MID: begin
        dx_nxt = EW'(a5) - EW'(sx5);
        dy_nxt = EW'(b5) - EW'(sy5);
      end
      default: begin
        dx_nxt = EW'(a5);
        dy_nxt = EW'(b5);
      end
    endcase
  end

  assign dist7 = XW'(sqx_r) + XW'(sqy_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r  <= dx_nxt;
      dy_r  <= dy_nxt;
      sqx_r <= QDW'(dx_r * dx_r);
      sqy_r <= QDW'(dy_r * dy_r);
      hit_r <= (dist7 < XW'(msq_r));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, hit_r};

  a_accept_enters : assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> v1_r)
    else $error("accepted item did not enter the pipeline");

  a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(v1_r) && $stable(v6_r) && $stable(v7_r) && $stable(hit_r)))
    else $error("pipeline moved during a stall");

  a_quotient_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (vx5 && (path5 == pnst_pkg::PATH_MID)) |-> ((qx5 <= magc5) && (vx5 == vy5)))
    else $error("projection quotient out of range");

endmodule
